[rtl/core/btt_pkg.sv]
`default_nettype none

package btt_pkg;

  // Lexer modes
  localparam logic [2:0] M_IDLE   = 3'd0;
  localparam logic [2:0] M_IDENT  = 3'd1;
  localparam logic [2:0] M_NUMBER = 3'd2;
  localparam logic [2:0] M_STRING = 3'd3;
  localparam logic [2:0] M_ESC    = 3'd4;
  localparam logic [2:0] M_RAW    = 3'd5;
  localparam logic [2:0] M_HALT   = 3'd6;

  // Token types
  localparam logic [3:0] T_IDENT  = 4'd0;
  localparam logic [3:0] T_OPEN   = 4'd1;
  localparam logic [3:0] T_CLOSE  = 4'd2;
  localparam logic [3:0] T_COLON  = 4'd3;
  localparam logic [3:0] T_COMMA  = 4'd4;
  localparam logic [3:0] T_NUMBER = 4'd5;
  localparam logic [3:0] T_STRING = 4'd6;
  localparam logic [3:0] T_DOC    = 4'd7;
  localparam logic [3:0] T_RAW    = 4'd8;
  localparam logic [3:0] T_STOP   = 4'd9;
  localparam logic [3:0] T_END    = 4'd10;

  // Fault codes
  localparam logic [2:0] F_NONE    = 3'd0;
  localparam logic [2:0] F_COLON   = 3'd1;
  localparam logic [2:0] F_VALUE   = 3'd2;
  localparam logic [2:0] F_NO_ELEM = 3'd3;
  localparam logic [2:0] F_CLOSE   = 3'd4;
  localparam logic [2:0] F_OPEN    = 3'd5;
  localparam logic [2:0] F_DOC     = 3'd6;

  // Attribute phases
  localparam logic [1:0] PH_NONE  = 2'd0;
  localparam logic [1:0] PH_NAME  = 2'd1;
  localparam logic [1:0] PH_VALUE = 2'd2;

  // Byte classes, assigned by the front end
  localparam logic [3:0] CL_WS      = 4'd0;
  localparam logic [3:0] CL_OPEN    = 4'd1;
  localparam logic [3:0] CL_CLOSE   = 4'd2;
  localparam logic [3:0] CL_COMMA   = 4'd3;
  localparam logic [3:0] CL_COLON   = 4'd4;
  localparam logic [3:0] CL_DOC     = 4'd5;
  localparam logic [3:0] CL_ALPHA   = 4'd6;
  localparam logic [3:0] CL_ALPHA_E = 4'd7;
  localparam logic [3:0] CL_DIGIT   = 4'd8;
  localparam logic [3:0] CL_SIGN    = 4'd9;
  localparam logic [3:0] CL_DOT     = 4'd10;
  localparam logic [3:0] CL_QUOTE   = 4'd11;
  localparam logic [3:0] CL_BSLASH  = 4'd12;
  localparam logic [3:0] CL_OTHER   = 4'd13;

  // Characters of interest
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_LOW_E  = 8'h65;
  localparam logic [7:0] CH_UP_E   = 8'h45;

  typedef struct packed {
    logic [2:0] mode;
    logic [6:0] depth;
    logic       elem;
    logic [1:0] phase;
  } lex_state_t;

  typedef struct packed {
    logic       action;
    logic [3:0] cls;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

  typedef struct packed {
    logic [3:0] ttype;
    logic       cv;
    logic [7:0] ch;
    logic       tstart;
    logic       tend;
    logic [6:0] depth;
    logic [2:0] fault;
    logic       last;
  } token_t;

  typedef struct packed {
    lex_state_t st;
    logic [2:0] fault;
  } check_t;

  typedef struct packed {
    logic       hit;
    token_t     tok;
    lex_state_t st;
  } lex_out_t;

  // Build one token beat; content byte reads as zero when not valid
  function automatic token_t mk_tok(input logic [3:0] ttype, input logic cv,
                                    input logic [7:0] ch, input logic tstart,
                                    input logic tend, input logic [6:0] depth,
                                    input logic [2:0] fault);
    token_t t;
    t.ttype  = ttype;
    t.cv     = cv;
    t.ch     = cv ? ch : 8'h00;
    t.tstart = tstart;
    t.tend   = tend;
    t.depth  = depth;
    t.fault  = fault;
    t.last   = 1'b0;
    return t;
  endfunction

  // Structural check of one complete token
  function automatic check_t tok_check(input lex_state_t s, input logic [3:0] kind,
                                       input logic [6:0] max_depth);
    check_t c;
    c.st    = s;
    c.fault = F_NONE;
    if (s.phase == PH_VALUE) begin
      if (kind == T_NUMBER || kind == T_STRING) begin
        c.st.phase = PH_NONE;
      end else begin
        c.fault = F_VALUE;
      end
    end else if (s.phase == PH_NAME && kind == T_COLON) begin
      c.st.phase = PH_VALUE;
    end else begin
      c.st.phase = PH_NONE;
      unique case (kind) inside
        T_IDENT: begin
          if (!s.elem) c.st.elem = 1'b1;
          else c.st.phase = PH_NAME;
        end
        T_OPEN: begin
          if (!s.elem || s.depth >= max_depth) begin
            c.fault = F_OPEN;
          end else begin
            c.st.depth = s.depth + 7'd1;
            c.st.elem  = 1'b0;
          end
        end
        T_CLOSE: begin
          if (s.depth == 7'd0) begin
            c.fault = F_CLOSE;
          end else begin
            c.st.depth = s.depth - 7'd1;
            c.st.elem  = 1'b0;
          end
        end
        T_COMMA: c.st.elem = 1'b0;
        T_COLON: c.fault = F_COLON;
        T_DOC: begin
          if (s.depth != 7'd0 || s.elem) c.fault = F_DOC;
        end
        T_NUMBER, T_STRING: begin
          if (!s.elem) c.fault = F_NO_ELEM;
        end
        default: ;
      endcase
    end
    return c;
  endfunction

  // Handle a byte that arrives with no token open
  function automatic lex_out_t lex_idle(input lex_state_t s, input item_t it,
                                        input logic [6:0] max_depth);
    lex_out_t   o;
    check_t     c;
    logic [3:0] kind;
    o.hit = 1'b0;
    o.tok = '0;
    o.st  = s;
    unique case (it.cls)
      CL_OPEN:  kind = T_OPEN;
      CL_CLOSE: kind = T_CLOSE;
      CL_COMMA: kind = T_COMMA;
      CL_COLON: kind = T_COLON;
      CL_DOC:   kind = T_DOC;
      default:  kind = T_STOP;
    endcase
    if (it.cls == CL_WS) begin
      o.hit = 1'b0;
    end else if (it.cls == CL_ALPHA || it.cls == CL_ALPHA_E) begin
      o.hit     = 1'b1;
      o.tok     = mk_tok(T_IDENT, 1'b1, it.data, 1'b1, 1'b0, s.depth, F_NONE);
      o.st.mode = M_IDENT;
    end else if (it.cls == CL_QUOTE) begin
      o.hit     = 1'b1;
      o.tok     = mk_tok(T_STRING, 1'b0, it.data, 1'b1, 1'b0, s.depth, F_NONE);
      o.st.mode = M_STRING;
    end else if (it.cls == CL_DIGIT || it.cls == CL_SIGN) begin
      o.hit     = 1'b1;
      o.tok     = mk_tok(T_NUMBER, 1'b1, it.data, 1'b1, 1'b0, s.depth, F_NONE);
      o.st.mode = M_NUMBER;
    end else begin
      // punctuation, or a byte that starts nothing
      c     = tok_check(s, kind, max_depth);
      o.st  = c.st;
      o.hit = 1'b1;
      o.tok = mk_tok(kind, 1'b1, it.data, 1'b1, 1'b1, c.st.depth, c.fault);
      if (c.fault != F_NONE || kind == T_STOP) o.st.mode = M_HALT;
      else if (kind == T_DOC) o.st.mode = M_RAW;
      else o.st.mode = M_IDLE;
    end
    return o;
  endfunction

endpackage

`default_nettype wire

[rtl/core/btt_front.sv]
`default_nettype none

module btt_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             action,
  input  wire logic [7:0]       byte_value,
  output btt_pkg::q_head_t      head,
  input  wire logic             pop
);
  import btt_pkg::*;

  item_t      mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  item_t      item_in;

  // Sort a byte into the class the lexer acts on
  function automatic logic [3:0] classify(input logic [7:0] b);
    logic [3:0] cl;
    unique case (b) inside
      8'h20, 8'h09, 8'h0D, 8'h0A: cl = CL_WS;
      8'h7B:                      cl = CL_OPEN;
      8'h7D:                      cl = CL_CLOSE;
      8'h2C:                      cl = CL_COMMA;
      8'h3A:                      cl = CL_COLON;
      CH_AT:                      cl = CL_DOC;
      CH_LOW_E, CH_UP_E:          cl = CL_ALPHA_E;
      [8'h61:8'h64], [8'h66:8'h7A], [8'h41:8'h44], [8'h46:8'h5A], CH_USCORE:
                                  cl = CL_ALPHA;
      [8'h30:8'h39]:              cl = CL_DIGIT;
      8'h2B, 8'h2D:               cl = CL_SIGN;
      CH_DOT:                     cl = CL_DOT;
      CH_QUOTE:                   cl = CL_QUOTE;
      CH_BSLASH:                  cl = CL_BSLASH;
      default:                    cl = CL_OTHER;
    endcase
    return cl;
  endfunction

  assign item_in.action = action;
  assign item_in.cls    = classify(byte_value);
  assign item_in.data   = byte_value;

  assign in_ready   = (count != 2'd2);
  assign push       = in_valid && in_ready;
  assign head.valid = (count != 2'd0);
  assign head.item  = mem[rd_ptr];

  // Store classified beats
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= item_in;
  end

  // Advance queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

endmodule

`default_nettype wire

[rtl/core/btt_back.sv]
`default_nettype none

module btt_back #(
  parameter int unsigned MAX_DEPTH = 64
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire btt_pkg::q_head_t head,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output btt_pkg::token_t       out_tok
);
  import btt_pkg::*;

  localparam logic [6:0] MaxD = 7'(MAX_DEPTH);

  lex_state_t state;
  lex_state_t state_next;
  token_t     tok0;
  token_t     tok1;
  logic       hit0;
  logic       hit1;
  token_t     pend_tok;
  logic       pend_valid;
  logic       slot_free;

  // Work out the beats one item causes and the state it leaves
  always_comb begin
    lex_out_t   a;
    check_t     c;
    lex_state_t s;
    item_t      it;
    logic       fin;
    logic [3:0] fin_kind;
    logic       ok;
    logic [2:0] f;
    token_t     end_tok;

    it       = head.item;
    s        = state;
    hit0     = 1'b0;
    hit1     = 1'b0;
    tok0     = '0;
    tok1     = '0;
    fin      = 1'b0;
    fin_kind = T_IDENT;
    ok       = 1'b1;
    f        = F_NONE;
    a        = '0;
    c        = '0;
    end_tok  = '0;

    if (it.action) begin
      // close any open identifier or number, then report end of input
      if (s.mode == M_IDENT || s.mode == M_NUMBER) begin
        fin_kind = (s.mode == M_IDENT) ? T_IDENT : T_NUMBER;
        c        = tok_check(s, fin_kind, MaxD);
        s        = c.st;
        hit0     = 1'b1;
        tok0     = mk_tok(fin_kind, 1'b0, 8'h00, 1'b0, 1'b1, s.depth, c.fault);
        s.mode   = (c.fault != F_NONE) ? M_HALT : M_IDLE;
        ok       = (c.fault == F_NONE);
      end
      if (ok && s.mode != M_RAW && s.mode != M_HALT) begin
        c = tok_check(s, T_STOP, MaxD);
        s = c.st;
        f = c.fault;
      end
      end_tok = mk_tok(T_END, 1'b0, 8'h00, 1'b1, 1'b1, s.depth, f);
      if (hit0) begin
        hit1 = 1'b1;
        tok1 = end_tok;
      end else begin
        hit0 = 1'b1;
        tok0 = end_tok;
      end
      s = '{mode: M_IDLE, depth: 7'd0, elem: 1'b0, phase: PH_NONE};
    end else begin
      unique case (s.mode)
        M_IDLE: begin
          a    = lex_idle(s, it, MaxD);
          hit0 = a.hit;
          tok0 = a.tok;
          s    = a.st;
        end
        M_IDENT: begin
          if (it.cls == CL_ALPHA || it.cls == CL_ALPHA_E || it.cls == CL_DIGIT ||
              it.cls == CL_DOT) begin
            hit0 = 1'b1;
            tok0 = mk_tok(T_IDENT, 1'b1, it.data, 1'b0, 1'b0, s.depth, F_NONE);
          end else begin
            fin      = 1'b1;
            fin_kind = T_IDENT;
          end
        end
        M_NUMBER: begin
          if (it.cls == CL_DIGIT || it.cls == CL_SIGN || it.cls == CL_ALPHA_E ||
              it.cls == CL_DOT) begin
            hit0 = 1'b1;
            tok0 = mk_tok(T_NUMBER, 1'b1, it.data, 1'b0, 1'b0, s.depth, F_NONE);
          end else begin
            fin      = 1'b1;
            fin_kind = T_NUMBER;
          end
        end
        M_STRING: begin
          if (it.cls == CL_BSLASH) begin
            s.mode = M_ESC;
          end else if (it.cls == CL_QUOTE) begin
            fin      = 1'b1;
            fin_kind = T_STRING;
          end else begin
            hit0 = 1'b1;
            tok0 = mk_tok(T_STRING, 1'b1, it.data, 1'b0, 1'b0, s.depth, F_NONE);
          end
        end
        M_ESC: begin
          hit0   = 1'b1;
          tok0   = mk_tok(T_STRING, 1'b1, it.data, 1'b0, 1'b0, s.depth, F_NONE);
          s.mode = M_STRING;
        end
        M_RAW: begin
          hit0 = 1'b1;
          tok0 = mk_tok(T_RAW, 1'b1, it.data, 1'b1, 1'b1, s.depth, F_NONE);
        end
        default: s.mode = M_HALT;
      endcase

      // close the open token; a byte that ends an identifier or number is then lexed afresh
      if (fin) begin
        c      = tok_check(s, fin_kind, MaxD);
        s      = c.st;
        hit0   = 1'b1;
        tok0   = mk_tok(fin_kind, 1'b0, 8'h00, 1'b0, 1'b1, s.depth, c.fault);
        s.mode = (c.fault != F_NONE) ? M_HALT : M_IDLE;
        if (c.fault == F_NONE && fin_kind != T_STRING) begin
          a    = lex_idle(s, it, MaxD);
          hit1 = a.hit;
          tok1 = a.tok;
          s    = a.st;
        end
      end
    end

    // mark the final beat of this item
    if (hit1) tok1.last = 1'b1;
    else if (hit0) tok0.last = 1'b1;

    state_next = s;
  end

  assign slot_free = !out_valid || out_ready;
  assign pop       = head.valid && !pend_valid && slot_free;

  // Hold lexer state, output beat and the pending second beat
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= '{mode: M_IDLE, depth: 7'd0, elem: 1'b0, phase: PH_NONE};
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (pop) begin
        state      <= state_next;
        out_valid  <= hit0;
        pend_valid <= hit1;
      end else if (pend_valid && slot_free) begin
        out_valid  <= 1'b1;
        pend_valid <= 1'b0;
      end else if (out_ready) begin
        out_valid  <= 1'b0;
      end
    end
  end

  // Load payload registers
  always_ff @(posedge clk) begin
    if (pop) begin
      out_tok  <= tok0;
      pend_tok <= tok1;
    end else if (pend_valid && slot_free) begin
      out_tok  <= pend_tok;
    end
  end

endmodule

`default_nettype wire

[rtl/core/brace_tree_text_tokenizer_top.sv]
// Path: an accepted byte is stored in the two-entry front queue, then lexed into the output beat register.
// Throughput: one byte per cycle while m_axis is ready; a byte that closes an identifier or
// number and starts another token yields two beats and holds the lexer until the second is loaded.
// The lexer state register, updated once per byte, sets that rate.
// Reset: synchronous rst clears the queue, the lexer state and the output valids.
`default_nettype none

module brace_tree_text_tokenizer_top #(
  parameter int unsigned MAX_DEPTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] byte_value
  input  wire logic [0:0]  s_axis_tuser,   // [0] action
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [7:0] char_value, [8] token_start, [9] token_end, [16:10] nest_depth,
  // [19:17] fault, [23:20] zero
  output logic [23:0]      m_axis_tdata,
  output logic [4:0]       m_axis_tuser,   // [3:0] token_type, [4] char_valid
  output logic             m_axis_tlast    // last_of_input
);
  import btt_pkg::*;

  q_head_t head;
  logic    pop;
  token_t  tok;

  btt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .action     (s_axis_tuser[0]),
    .byte_value (s_axis_tdata),
    .head       (head),
    .pop        (pop)
  );

  btt_back #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_tok   (tok)
  );

  // Pack the result beat
  assign m_axis_tdata = {4'b0000, tok.fault, tok.depth, tok.tend, tok.tstart, tok.ch};
  assign m_axis_tuser = {tok.cv, tok.ttype};
  assign m_axis_tlast = tok.last;

`ifndef SYNTHESIS
  // Depth never passes the configured limit
  a_depth_limit: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[16:10] <= 7'(MAX_DEPTH)))
    else $error("nest depth beyond limit");

  // Faults are only raised on a beat that closes its token
  a_fault_end: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[19:17] != F_NONE) |-> m_axis_tdata[9])
    else $error("fault beat does not close its token");

  // End of input is a single framed beat that closes its item
  a_end_framed: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[3:0] == T_END) |->
      (m_axis_tdata[8] && m_axis_tdata[9] && m_axis_tlast && !m_axis_tuser[4]))
    else $error("end beat badly framed");
`endif

endmodule

`default_nettype wire

[tb/brace_tree_text_tokenizer_top_tb.sv]
module brace_tree_text_tokenizer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import btt_pkg::*;

  localparam int unsigned DEPTH_LIMIT = 64;
  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int ITEMS_PER_PHASE = 370;
  localparam int SHOWN_MISMATCHES = 10;
  localparam string NOISE_CHARS = "{}:,@\" \\azE9+-._$\n\t";
  localparam string NUM_CHARS = "0123456789+-eE.";

  typedef struct packed {
    logic       act;
    logic [7:0] value;
  } text_item_t;

  // One directed beat; tok holds the expected token when typed is set
  typedef struct packed {
    logic       act;
    logic [7:0] value;
    logic       typed;
    token_t     tok;
  } dir_row_t;

  localparam dir_row_t DIRECTED [25] = '{
    '{1'b0, 8'h7D, 1'b1, '{T_CLOSE, 1'b1, 8'h7D, 1'b1, 1'b1, 7'd0, F_CLOSE, 1'b1}},
    '{1'b1, 8'h00, 1'b1, '{T_END, 1'b0, 8'h00, 1'b1, 1'b1, 7'd0, F_NONE, 1'b1}},
    '{1'b0, "n", 1'b0, '0},
    '{1'b0, "{", 1'b0, '0},
    '{1'b0, "e", 1'b0, '0},
    '{1'b0, " ", 1'b0, '0},
    '{1'b0, "k", 1'b0, '0},
    '{1'b0, ":", 1'b0, '0},
    '{1'b0, "+", 1'b0, '0},
    '{1'b0, "E", 1'b0, '0},
    '{1'b0, ".", 1'b0, '0},
    '{1'b0, CH_QUOTE, 1'b0, '0},
    '{1'b0, CH_BSLASH, 1'b0, '0},
    '{1'b0, 8'hFF, 1'b0, '0},
    '{1'b0, 8'h00, 1'b0, '0},
    '{1'b0, CH_QUOTE, 1'b0, '0},
    '{1'b0, "}", 1'b0, '0},
    '{1'b0, CH_AT, 1'b0, '0},
    '{1'b0, 8'h00, 1'b0, '0},
    '{1'b0, 8'hFF, 1'b0, '0},
    '{1'b1, 8'hFF, 1'b1, '{T_END, 1'b0, 8'h00, 1'b1, 1'b1, 7'd0, F_NONE, 1'b1}},
    '{1'b0, "{", 1'b1, '{T_OPEN, 1'b1, 8'h7B, 1'b1, 1'b1, 7'd0, F_OPEN, 1'b1}},
    '{1'b1, 8'h00, 1'b1, '{T_END, 1'b0, 8'h00, 1'b1, 1'b1, 7'd0, F_NONE, 1'b1}},
    '{1'b0, "$", 1'b1, '{T_STOP, 1'b1, 8'h24, 1'b1, 1'b1, 7'd0, F_NONE, 1'b1}},
    '{1'b1, 8'h00, 1'b1, '{T_END, 1'b0, 8'h00, 1'b1, 1'b1, 7'd0, F_NONE, 1'b1}}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic [0:0]  s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [4:0]  m_axis_tuser;
  logic        m_axis_tlast;

  // Typed expectation riding along with the beat on offer
  logic   cur_typed = 1'b0;
  token_t cur_tok = '0;

  // Tokenizer state as predicted
  logic [2:0] lx_mode;
  logic [6:0] lx_depth;
  logic       lx_elem;
  logic [1:0] lx_phase;

  token_t     step_beats[$];
  token_t     expected_tokens[$];
  text_item_t doc[$];

  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  int         stall_req = 0;
  int         stall_seen = 0;
  int         hold_left = 0;
  int         mismatch_count = 0;
  int         text_beats = 0;
  int         token_beats = 0;
  int         doc_count = 0;
  int         quiet_cycles = 0;
  logic [6:0] max_depth_seen = '0;
  logic [7:0] faults_seen = '0;

  brace_tree_text_tokenizer_top #(.MAX_DEPTH(DEPTH_LIMIT)) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit is_letter(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == CH_USCORE;
  endfunction

  function automatic bit is_num_digit(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic void tokenizer_clear();
    lx_mode  = M_IDLE;
    lx_depth = '0;
    lx_elem  = 1'b0;
    lx_phase = PH_NONE;
  endfunction

  // Check one complete token against the nesting and attribute rules
  function automatic logic [2:0] judge(input logic [3:0] kind);
    if (lx_phase == PH_VALUE) begin
      if (kind == T_NUMBER || kind == T_STRING) begin
        lx_phase = PH_NONE;
        return F_NONE;
      end
      return F_VALUE;
    end
    if (lx_phase == PH_NAME && kind == T_COLON) begin
      lx_phase = PH_VALUE;
      return F_NONE;
    end
    lx_phase = PH_NONE;
    case (kind)
      T_IDENT: begin
        if (!lx_elem) lx_elem = 1'b1;
        else lx_phase = PH_NAME;
      end
      T_OPEN: begin
        if (!lx_elem || lx_depth >= DEPTH_LIMIT) return F_OPEN;
        lx_depth = lx_depth + 7'd1;
        lx_elem  = 1'b0;
      end
      T_CLOSE: begin
        if (lx_depth == 7'd0) return F_CLOSE;
        lx_depth = lx_depth - 7'd1;
        lx_elem  = 1'b0;
      end
      T_COMMA: lx_elem = 1'b0;
      T_COLON: return F_COLON;
      T_DOC: if (lx_depth != 7'd0 || lx_elem) return F_DOC;
      T_NUMBER, T_STRING: if (!lx_elem) return F_NO_ELEM;
      default: ;
    endcase
    return F_NONE;
  endfunction

  function automatic void put_beat(input logic [3:0] ty, input logic cv, input logic [7:0] ch,
                                   input logic st, input logic en, input logic [2:0] f);
    token_t t;
    t.ttype  = ty;
    t.cv     = cv;
    t.ch     = cv ? ch : 8'h00;
    t.tstart = st;
    t.tend   = en;
    t.depth  = lx_depth;
    t.fault  = f;
    t.last   = 1'b0;
    step_beats.insert(step_beats.size(), t);
  endfunction

  // Close a multi-byte token; true when it passed the structural check
  function automatic bit close_token(input logic [3:0] ty);
    logic [2:0] f;
    f = judge(ty);
    put_beat(ty, 1'b0, 8'h00, 1'b0, 1'b1, f);
    lx_mode = (f != F_NONE) ? M_HALT : M_IDLE;
    return f == F_NONE;
  endfunction

  // Handle a byte with no token open
  function automatic void start_byte(input logic [7:0] b);
    logic [3:0] kind;
    logic [2:0] f;
    if (b == 8'h20 || b == 8'h09 || b == 8'h0D || b == 8'h0A) return;
    case (b)
      8'h7B:   kind = T_OPEN;
      8'h7D:   kind = T_CLOSE;
      8'h2C:   kind = T_COMMA;
      8'h3A:   kind = T_COLON;
      CH_AT:   kind = T_DOC;
      default: kind = T_STOP;
    endcase
    if (kind == T_STOP && is_letter(b)) begin
      put_beat(T_IDENT, 1'b1, b, 1'b1, 1'b0, F_NONE);
      lx_mode = M_IDENT;
    end else if (kind == T_STOP && b == CH_QUOTE) begin
      put_beat(T_STRING, 1'b0, b, 1'b1, 1'b0, F_NONE);
      lx_mode = M_STRING;
    end else if (kind == T_STOP && (is_num_digit(b) || b == "-" || b == "+")) begin
      put_beat(T_NUMBER, 1'b1, b, 1'b1, 1'b0, F_NONE);
      lx_mode = M_NUMBER;
    end else begin
      f = judge(kind);
      put_beat(kind, 1'b1, b, 1'b1, 1'b1, f);
      if (f != F_NONE || kind == T_STOP) lx_mode = M_HALT;
      else if (kind == T_DOC) lx_mode = M_RAW;
    end
  endfunction

  // Predict the token beats caused by one accepted input beat
  function automatic void tokenize(input logic act, input logic [7:0] b);
    logic       ok;
    logic [2:0] f;
    step_beats.delete();
    if (act) begin
      ok = 1'b1;
      f  = F_NONE;
      if (lx_mode == M_IDENT) ok = close_token(T_IDENT);
      else if (lx_mode == M_NUMBER) ok = close_token(T_NUMBER);
      if (ok && lx_mode != M_RAW && lx_mode != M_HALT) f = judge(T_STOP);
      put_beat(T_END, 1'b0, 8'h00, 1'b1, 1'b1, f);
      tokenizer_clear();
    end else begin
      case (lx_mode)
        M_IDLE: start_byte(b);
        M_IDENT: begin
          if (is_letter(b) || is_num_digit(b) || b == CH_DOT)
            put_beat(T_IDENT, 1'b1, b, 1'b0, 1'b0, F_NONE);
          else if (close_token(T_IDENT))
            start_byte(b);
        end
        M_NUMBER: begin
          if (is_num_digit(b) || b == "-" || b == "+" || b == CH_LOW_E || b == CH_UP_E
              || b == CH_DOT)
            put_beat(T_NUMBER, 1'b1, b, 1'b0, 1'b0, F_NONE);
          else if (close_token(T_NUMBER))
            start_byte(b);
        end
        M_STRING: begin
          if (b == CH_BSLASH) lx_mode = M_ESC;
          else if (b == CH_QUOTE) void'(close_token(T_STRING));
          else put_beat(T_STRING, 1'b1, b, 1'b0, 1'b0, F_NONE);
        end
        M_ESC: begin
          put_beat(T_STRING, 1'b1, b, 1'b0, 1'b0, F_NONE);
          lx_mode = M_STRING;
        end
        M_RAW: put_beat(T_RAW, 1'b1, b, 1'b1, 1'b1, F_NONE);
        default: ;
      endcase
    end
    if (step_beats.size() != 0) step_beats[step_beats.size() - 1].last = 1'b1;
  endfunction

  function automatic string beat_text(input token_t t);
    return $sformatf("type %0d cv %0d char %02h start %0d end %0d depth %0d fault %0d last %0d",
                     t.ttype, t.cv, t.ch, t.tstart, t.tend, t.depth, t.fault, t.last);
  endfunction

  // Compare one output beat with the oldest expected token beat
  function automatic void check_beat(input token_t got);
    token_t want;
    string  bad;
    if (expected_tokens.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= SHOWN_MISMATCHES)
        $display("%0t: token beat with nothing expected: %s", $realtime, beat_text(got));
      return;
    end
    want = expected_tokens.pop_front();
    bad  = "";
    if (got.ttype !== want.ttype) bad = {bad, " type"};
    if (got.cv !== want.cv) bad = {bad, " char_valid"};
    if (got.ch !== want.ch) bad = {bad, " char"};
    if (got.tstart !== want.tstart) bad = {bad, " start"};
    if (got.tend !== want.tend) bad = {bad, " end"};
    if (got.depth !== want.depth) bad = {bad, " depth"};
    if (got.fault !== want.fault) bad = {bad, " fault"};
    if (got.last !== want.last) bad = {bad, " last"};
    if (bad != "") begin
      mismatch_count++;
      if (mismatch_count <= SHOWN_MISMATCHES) begin
        $display("%0t: token beat mismatch in%s", $realtime, bad);
        $display("  expected %s", beat_text(want));
        $display("  actual   %s", beat_text(got));
      end
    end
  endfunction

  // Receiver: random backpressure plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (stall_seen != stall_req) begin
      stall_seen    <= stall_req;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Predict on every input beat, check every output beat, watch for a hang
  always @(posedge clk) begin : watch
    token_t got;
    logic   moved;
    if (!rst) begin
      moved = 1'b0;
      if (s_axis_tvalid && s_axis_tready) begin
        moved = 1'b1;
        text_beats++;
        tokenize(s_axis_tuser[0], s_axis_tdata);
        if (cur_typed) begin
          step_beats.delete();
          step_beats.insert(0, cur_tok);
        end
        foreach (step_beats[i]) begin
          expected_tokens.insert(expected_tokens.size(), step_beats[i]);
          if (step_beats[i].depth > max_depth_seen) max_depth_seen = step_beats[i].depth;
          faults_seen[step_beats[i].fault] = 1'b1;
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        moved = 1'b1;
        token_beats++;
        got.ttype  = m_axis_tuser[3:0];
        got.cv     = m_axis_tuser[4];
        got.ch     = m_axis_tdata[7:0];
        got.tstart = m_axis_tdata[8];
        got.tend   = m_axis_tdata[9];
        got.depth  = m_axis_tdata[16:10];
        got.fault  = m_axis_tdata[19:17];
        got.last   = m_axis_tlast;
        check_beat(got);
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $realtime, QUIET_LIMIT);
        $display("brace_tree_text_tokenizer_top regression: fail");
        $finish;
      end
    end
  end

  // Offer one beat after a random gap and hold it until accepted
  task automatic send_beat(input logic act, input logic [7:0] value, input logic typed,
                           input token_t tok);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= value;
    cur_typed     <= typed;
    cur_tok       <= tok;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Stop offering until every expected token beat is out
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic push_text(input logic [7:0] v);
    doc.insert(doc.size(), '{1'b0, v});
  endtask

  task automatic add_space();
    case ($urandom_range(3))
      0: push_text(8'h20);
      1: push_text(8'h09);
      2: push_text(8'h0D);
      default: push_text(8'h0A);
    endcase
  endtask

  function automatic logic [7:0] noise_byte();
    if ($urandom_range(3) == 0) return 8'($urandom_range(255));
    return NOISE_CHARS[$urandom_range(NOISE_CHARS.len() - 1)];
  endfunction

  // Append an identifier followed by whitespace
  task automatic add_word();
    int k;
    k = $urandom_range(52);
    push_text(k < 26 ? 8'(8'h61 + k) : k < 52 ? 8'(8'h41 + k - 26) : CH_USCORE);
    repeat ($urandom_range(3)) begin
      k = $urandom_range(38);
      if (k < 26) push_text(8'(8'h61 + k));
      else if (k < 36) push_text(8'(8'h30 + k - 26));
      else if (k < 37) push_text(CH_DOT);
      else push_text(CH_USCORE);
    end
    add_space();
  endtask

  // Append a number or a quoted string with escapes
  task automatic add_value();
    logic [7:0] c;
    if ($urandom_range(1)) begin
      push_text(NUM_CHARS[$urandom_range(11)]);
      repeat ($urandom_range(4)) push_text(NUM_CHARS[$urandom_range(NUM_CHARS.len() - 1)]);
      add_space();
    end else begin
      push_text(CH_QUOTE);
      repeat ($urandom_range(5)) begin
        c = 8'($urandom_range(255));
        if (c == CH_QUOTE || c == CH_BSLASH || $urandom_range(5) == 0) push_text(CH_BSLASH);
        push_text(c);
      end
      push_text(CH_QUOTE);
      if ($urandom_range(1)) add_space();
    end
  endtask

  // Append one well-formed element with attributes and children
  task automatic add_element(input int lvl);
    int n;
    add_word();
    repeat ($urandom_range(2)) begin
      add_word();
      if ($urandom_range(4) != 0) begin
        push_text(":");
        if ($urandom_range(1)) add_space();
        add_value();
      end
    end
    if ($urandom_range(9) == 0) add_value();
    if (lvl < 3 && $urandom_range(2) == 0) begin
      push_text("{");
      n = $urandom_range(2);
      for (int i = 0; i < n; i++) begin
        if (i > 0) push_text(",");
        add_element(lvl + 1);
      end
      push_text("}");
      if ($urandom_range(1)) add_space();
    end
  endtask

  // Build one input sequence ending in end of input
  task automatic build_document(input bit deep);
    int pick;
    int n;
    doc.delete();
    doc_count++;
    pick = deep ? 0 : $urandom_range(99);
    if (pick < 3) begin
      // nest right up to the depth limit, overshoot half the time
      n = DEPTH_LIMIT + $urandom_range(1);
      repeat (n) begin
        push_text("a");
        push_text("{");
      end
      if (n == DEPTH_LIMIT) repeat (n) push_text("}");
    end else if (pick < 72) begin
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) begin
        if (i > 0) push_text($urandom_range(1) ? "," : " ");
        add_element(0);
      end
      if ($urandom_range(1)) begin
        push_text(CH_AT);
        repeat ($urandom_range(6)) push_text(8'($urandom_range(255)));
      end
      // break some sequences: cut short or drop in a stray byte
      if (pick >= 57) begin
        if ($urandom_range(1)) doc = doc[0:$urandom_range(doc.size() - 1)];
        else doc[$urandom_range(doc.size() - 1)].value = noise_byte();
      end
    end else if (pick < 90) begin
      repeat ($urandom_range(3, 15)) push_text(noise_byte());
    end else begin
      repeat ($urandom_range(1, 8)) push_text(8'($urandom_range(255)));
    end
    doc.insert(doc.size(), '{1'b1, 8'h00});
  endtask

  initial begin : stimulus
    int phase_items;
    tokenizer_clear();
    send_idle_pct = 36;
    recv_idle_pct = 57;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table
    foreach (DIRECTED[i])
      send_beat(DIRECTED[i].act, DIRECTED[i].value, DIRECTED[i].typed, DIRECTED[i].tok);
    drain();

    // Random documents under three idling mixes, each opening with a long hold-off
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 36 : (ph == 1) ? 57 : 0;
      recv_idle_pct = (ph == 0) ? 57 : (ph == 1) ? 36 : 0;
      stall_req <= stall_req + 1;
      phase_items = 0;
      while (phase_items < ITEMS_PER_PHASE) begin
        build_document(ph == 0 && phase_items == 0);
        foreach (doc[i]) send_beat(doc[i].act, doc[i].value, 1'b0, '0);
        phase_items += doc.size();
      end
      drain();
    end

    repeat (20) @(posedge clk);
    $display("covered %0d input beats in %0d sequences, %0d token beats checked",
             text_beats, doc_count, token_beats);
    $display("deepest nesting %0d, fault codes raised %b, mismatches %0d",
             max_depth_seen, faults_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("brace_tree_text_tokenizer_top regression: pass");
    end else begin
      $display("brace_tree_text_tokenizer_top regression: fail");
    end
    $finish;
  end

endmodule

[brace_tree_text_tokenizer_top.f]
rtl/core/btt_pkg.sv
rtl/core/btt_front.sv
rtl/core/btt_back.sv
rtl/core/brace_tree_text_tokenizer_top.sv
tb/brace_tree_text_tokenizer_top_tb.sv
